@@ design/andf_pkg.sv @@
// package for the annex b nal deframer
// result and queue entry types, result kind codes, phase encoding, byte constants
// no dependencies
`timescale 1ns / 1ps

package andf_pkg;

    localparam int MaxRes            = 5;
    localparam int CountW            = $clog2(MaxRes + 1);
    localparam int SlotW             = $clog2(MaxRes);
    localparam int QueueDepthDefault = 4;

    localparam logic [7:0] StartCodeByte = 8'h01;
    localparam logic [7:0] EscapeByte    = 8'h03;
    localparam logic [7:0] TypeMask      = 8'h1f;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_END      = 2'd2,
        KIND_NO_START = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_HEADER = 3'b010,
        PH_UNIT   = 3'b100
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload;
        logic [1:0]  ref_level;
        logic [4:0]  unit_type;
    } result_t;

    typedef struct packed {
        logic [CountW-1:0]         count;
        result_t [MaxRes-1:0]      res;
    } entry_t;

endpackage

@@ design/andf_if.sv @@
// word channels of the deframer: input byte channel and result channel
// depends on andf_pkg for the result kind type
`timescale 1ns / 1ps

interface andf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface andf_out_if
    import andf_pkg::*;
    ;
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] payload;
    logic [1:0] ref_level;
    logic [4:0] unit_type;
    logic       run_last;

    modport source (output valid, output kind, output payload, output ref_level,
                    output unit_type, output run_last, input ready);
    modport sink   (input valid, input kind, input payload, input ref_level,
                    input unit_type, input run_last, output ready);
endinterface

@@ design/annexb_nal_deframer_top.sv @@
// annex b byte-stream nal deframer, top level
// depends on andf_pkg, andf_if, andf_front, andf_queue, andf_back
`timescale 1ns / 1ps

// Takes a frame one byte word per clock on the frame channel (end_of_frame on
// its last byte) and gives result words on the result channel: for each nal
// unit a header word (ref_level, unit_type), its payload bytes with
// emulation-prevention 0x03 bytes removed, and an end-of-unit word; a frame
// with no start code gives one no-start word. Bytes before the first start
// code are dropped and the whole two- or three-zero start code is stripped.
// A byte gives zero to five result words; run_last marks the last word of a
// byte. The front end takes one byte every clock and writes its whole group
// of words into a queue of QUEUE_DEPTH groups; a byte with no words takes no
// queue slot. The back end hands out one word per clock while the result
// channel is ready, so a byte that gives k words holds the result side until
// all k are taken, and the front only stalls when the queue is full. When the
// queue is empty, the first word of a byte passes the queue memory and then
// the back end's group register before it is valid.

module annexb_nal_deframer_top
    import andf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    andf_in_if.sink     frame,
    andf_out_if.source  result
);

    // front to queue
    logic    push;
    entry_t  wr_data;
    logic    full;

    // queue to back
    logic    pop;
    entry_t  rd_data;
    logic    avail;

    // byte classification and result group building
    andf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame),
        .full    (full),
        .push    (push),
        .wr_data (wr_data)
    );

    // group queue, decouples the byte side from the word side
    andf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_data),
        .avail   (avail)
    );

    // group serializer, one result word per clock while the result channel is ready
    andf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .avail   (avail),
        .rd_data (rd_data),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ design/andf_front.sv @@
// front end: start code tracking, zero holding, emulation removal per byte
// builds the full result group of one byte; depends on andf_pkg and andf_in_if
`timescale 1ns / 1ps

module andf_front
    import andf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    andf_in_if.sink       frame,
    input  logic          full,
    output logic          push,
    output entry_t        wr_data
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  zero_run_reg, zero_run_next;
    logic [1:0]  held_reg, held_next;
    logic [1:0]  emul_reg, emul_next;
    logic        unit_open_reg, unit_open_next;

    logic        accept;
    entry_t      ent;

    assign frame.ready = !full;
    assign accept      = frame.valid && frame.ready;
    assign push        = accept && (ent.count != '0);
    assign wr_data     = ent;

    always_comb
    begin
        phase_t      ph;
        logic [2:0]  zr;
        logic [1:0]  hz;
        logic [1:0]  ec;
        logic        uo;
        logic [CountW-1:0] n;
        logic [1:0]  nz;
        logic        del;
        logic [7:0]  db;

        ph  = phase_reg;
        zr  = zero_run_reg;
        hz  = held_reg;
        ec  = emul_reg;
        uo  = unit_open_reg;
        n   = '0;
        nz  = '0;
        del = 1'b0;
        db  = '0;
        ent = '0;

        // sort the byte: zero, start code end, or plain data
        if (frame.data_byte == 8'h00)
        begin
            zr = (zr < 3'd4) ? zr + 3'd1 : 3'd4;
            if (ph != PH_SEARCH)
            begin
                if (zr <= 3'd3)
                begin
                    hz = zr[1:0];
                end
                else
                begin
                    nz  = hz;
                    del = 1'b1;
                    hz  = '0;
                end
            end
        end
        else if (frame.data_byte == StartCodeByte && (zr == 3'd2 || zr == 3'd3))
        begin
            hz = '0;
            if (uo)
            begin
                ent.res[n].kind = KIND_END;
                n = n + 1'b1;
            end
            ph = PH_HEADER;
            uo = 1'b0;
            zr = '0;
            ec = '0;
        end
        else
        begin
            zr = '0;
            if (ph != PH_SEARCH)
            begin
                nz  = hz;
                del = 1'b1;
                hz  = '0;
            end
        end

        // frame end flushes zeros still held back
        if (frame.end_of_frame && ph != PH_SEARCH && hz != '0)
        begin
            nz = hz;
            hz = '0;
        end

        // held zeros first, then the byte itself
        for (int j = 0; j < 4; j++)
        begin
            if (j < int'(nz) || (j == int'(nz) && del))
            begin
                db = (j < int'(nz)) ? 8'h00 : frame.data_byte;
                if (ph == PH_HEADER)
                begin
                    if (int'(n) < MaxRes)
                    begin
                        ent.res[n].kind      = KIND_HEADER;
                        ent.res[n].ref_level = db[6:5];
                        ent.res[n].unit_type = 5'(db & TypeMask);
                        n = n + 1'b1;
                    end
                    ph = PH_UNIT;
                    uo = 1'b1;
                    ec = '0;
                end
                else if (ec == 2'd2 && db == EscapeByte)
                begin
                    ec = '0;
                end
                else
                begin
                    if (int'(n) < MaxRes)
                    begin
                        ent.res[n].kind    = KIND_PAYLOAD;
                        ent.res[n].payload = db;
                        n = n + 1'b1;
                    end
                    if (db == 8'h00)
                        ec = (ec < 2'd3) ? ec + 2'd1 : 2'd3;
                    else
                        ec = '0;
                end
            end
        end

        if (frame.end_of_frame)
        begin
            if (ph == PH_SEARCH)
            begin
                if (int'(n) < MaxRes)
                begin
                    ent.res[n].kind = KIND_NO_START;
                    n = n + 1'b1;
                end
            end
            else if (uo)
            begin
                if (int'(n) < MaxRes)
                begin
                    ent.res[n].kind = KIND_END;
                    n = n + 1'b1;
                end
            end
            ph = PH_SEARCH;
            zr = '0;
            hz = '0;
            ec = '0;
            uo = 1'b0;
        end

        ent.count      = n;
        phase_next     = ph;
        zero_run_next  = zr;
        held_next      = hz;
        emul_next      = ec;
        unit_open_next = uo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            zero_run_reg  <= '0;
            held_reg      <= '0;
            emul_reg      <= '0;
            unit_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            zero_run_reg  <= zero_run_next;
            held_reg      <= held_next;
            emul_reg      <= emul_next;
            unit_open_reg <= unit_open_next;
        end
    end

`ifndef SYNTHESIS
    a_zero_run_sat: assert property (@(posedge clk) disable iff (!rst_n)
        zero_run_reg <= 3'd4)
        else $error("zero run beyond saturation");

    a_held_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != '0 |-> phase_reg != PH_SEARCH)
        else $error("zeros held before any start code");

    a_open_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
        unit_open_reg |-> phase_reg == PH_UNIT)
        else $error("unit open outside unit phase");
`endif

endmodule

@@ design/andf_queue.sv @@
// small register queue of result groups between front and back
// depends on andf_pkg for the entry type
`timescale 1ns / 1ps

module andf_queue
    import andf_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t wr_data,
    output logic   full,
    input  logic   pop,
    output entry_t rd_data,
    output logic   avail
);

    localparam int IdxW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    entry_t            mem_reg [DEPTH];
    logic [IdxW-1:0]   wr_idx_reg, wr_idx_next;
    logic [IdxW-1:0]   rd_idx_reg, rd_idx_next;
    logic [CntW-1:0]   count_reg, count_next;

    assign full    = (count_reg == CntW'(DEPTH));
    assign avail   = (count_reg != '0);
    assign rd_data = mem_reg[rd_idx_reg];

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (push)
            wr_idx_next = (wr_idx_reg == IdxW'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
        if (pop)
            rd_idx_next = (rd_idx_reg == IdxW'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_idx_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");
`endif

endmodule

@@ design/andf_back.sv @@
// back end: takes one result group at a time and hands out its words in order
// depends on andf_pkg and andf_out_if
`timescale 1ns / 1ps

module andf_back
    import andf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        avail,
    input  entry_t      rd_data,
    output logic        pop,
    andf_out_if.source  result
);

    entry_t             cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    logic [SlotW-1:0]   idx_reg, idx_next;

    logic               fire;
    logic               last;
    logic               load;
    result_t            slot;

    assign slot   = cur_reg.res[idx_reg];
    assign last   = (CountW'(idx_reg) == cur_reg.count - 1'b1);
    assign fire   = result.valid && result.ready;
    assign load   = !cur_valid_reg || (fire && last);
    assign pop    = load && avail;

    assign result.valid     = cur_valid_reg;
    assign result.kind      = slot.kind;
    assign result.payload   = slot.payload;
    assign result.ref_level = slot.ref_level;
    assign result.unit_type = slot.unit_type;
    assign result.run_last  = last;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_next       = rd_data;
            cur_valid_next = avail;
            idx_next       = '0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

`ifndef SYNTHESIS
    a_slot_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.count != '0 && CountW'(idx_reg) < cur_reg.count))
        else $error("result slot outside its group");
`endif

endmodule
